// ===== rtl/bbs_squaring_bit_generator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the squaring bit generator
// Shared forms for concurrent checks clocked on clk with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef BBS_SQUARING_BIT_GENERATOR_ASSERT_SVH
`define BBS_SQUARING_BIT_GENERATOR_ASSERT_SVH

// Same-cycle implication check.
`define BBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define BBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bbs_pkg.sv =====
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared constants, codes and types of the squaring bit generator.
// ----------------------------------------------------------------------------
package bbs_pkg;

  localparam int WIDTH_DEF = 32;
  localparam int CFG_W     = 32;
  localparam int BCNT_W    = 4;
  localparam int BYTE_W    = 8;

  localparam logic [BCNT_W-1:0] MAX_BITS = 4'd8;
  localparam logic [BYTE_W-1:0] FIRST_BIT = 8'h80;

  typedef enum logic {
    CMD_GENERATE = 1'b0,
    CMD_RESTART  = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_MODULUS = 1'b0,
    REG_SEED    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

// ===== rtl/bbs_squaring_bit_generator.sv =====
// ----------------------------------------------------------------------------
// bbs_squaring_bit_generator
// Blum Blum Shub bit generator with an iterative shift-add modular squarer.
// ----------------------------------------------------------------------------
// The modulus and the seed must be written through the cfg_ port only while
// the block is idle; the block itself does not enforce this. Each request on
// the in_ channel carries a command in in_tuser and a bit count in in_tdata.
// A restart request loads the running value from the seed if the seed is
// nonzero and below the modulus, and else flags an error; its result then
// passes through T_FIN to the output register. A generate request makes one
// modular squaring per bit on one shared modular adder. A squaring first
// reduces the running value if it is not below the modulus, then doubles
// the accumulator per bit of the value and adds the reduced value per set bit.
// One request is in flight at a time; in_tready is low while it is worked on.
// Every request gives one result on the out_ channel: the bit byte in
// out_tdata and the error flag in out_tuser. The result sits in an output
// register; a stalled receiver holds the next result back, and in_tready
// returns once the result register is loaded.
// Reset clears the state, the output valid flag, the modulus and seed registers,
// the running value and the squaring count.
`include "bbs_squaring_bit_generator_assert.svh"

module bbs_squaring_bit_generator
  import bbs_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [3:0] nbits, [7:4] zero
  input  logic              in_tuser,   // [0] command
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] data_byte
  output logic              out_tuser   // [0] error
);

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_STEP = 4'b0010,
    T_WAIT = 4'b0100,
    T_FIN  = 4'b1000
  } top_state_t;

  top_state_t         st_r, st_nxt;
  logic [WIDTH-1:0]   modulus_r;
  logic [WIDTH-1:0]   seed_r;
  logic [WIDTH-1:0]   cur_r, cur_nxt;
  logic [31:0]        sqcnt_r, sqcnt_nxt;
  logic [BCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BCNT_W-1:0]  k_r, k_nxt;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic               err_r, err_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic               out_err_r, out_err_nxt;
  logic               mm_start;
  logic [WIDTH-1:0]   mm_result;
  mm_stat_t           mm_stat;
  logic [BCNT_W-1:0]  in_count;
  logic               in_fire;

  bbs_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .a      (cur_r),
    .m      (modulus_r),
    .result (mm_result),
    .stat   (mm_stat)
  );

  assign in_tready = (st_r == T_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_count  = (in_tdata[BCNT_W-1:0] > MAX_BITS) ? MAX_BITS : in_tdata[BCNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= '0;
      seed_r    <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_MODULUS: modulus_r <= WIDTH'(cfg_wdata);
        REG_SEED:    seed_r    <= WIDTH'(cfg_wdata);
        default:     modulus_r <= modulus_r;
      endcase
    end
  end

  always_comb begin
    st_nxt        = st_r;
    cur_nxt       = cur_r;
    sqcnt_nxt     = sqcnt_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    byte_nxt      = byte_r;
    err_nxt       = err_r;
    mm_start      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_err_nxt   = out_err_r;
    unique case (st_r)
      T_IDLE: begin
        if (in_fire) begin
          byte_nxt = '0;
          err_nxt  = 1'b0;
          k_nxt    = '0;
          cnt_nxt  = in_count;
          if (cmd_t'(in_tuser) == CMD_RESTART) begin
            if (seed_r == '0 || seed_r >= modulus_r) begin
              err_nxt = 1'b1;
            end else begin
              cur_nxt   = seed_r;
              sqcnt_nxt = '0;
            end
            st_nxt = T_FIN;
          end else begin
            st_nxt = T_STEP;
          end
        end
      end
      T_STEP: begin
        if (k_r == cnt_r) begin
          st_nxt = T_FIN;
        end else if (modulus_r == '0 || cur_r == '0) begin
          err_nxt  = 1'b1;
          byte_nxt = '0;
          st_nxt   = T_FIN;
        end else begin
          mm_start = 1'b1;
          st_nxt   = T_WAIT;
        end
      end
      T_WAIT: begin
        if (mm_stat.done) begin
          cur_nxt   = mm_result;
          sqcnt_nxt = sqcnt_r + 32'd1;
          if (mm_result[0]) begin
            byte_nxt = byte_r | (FIRST_BIT >> k_r);
          end
          k_nxt  = k_r + 1'b1;
          st_nxt = T_STEP;
        end
      end
      T_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = byte_r;
          out_err_nxt   = err_r;
          st_nxt        = T_IDLE;
        end
      end
      default: begin
        st_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      out_valid_r <= 1'b0;
      cur_r       <= '0;
      sqcnt_r     <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
      sqcnt_r     <= sqcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    k_r        <= k_nxt;
    byte_r     <= byte_nxt;
    err_r      <= err_nxt;
    out_byte_r <= out_byte_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_err_r;

  `BBS_ASSERT_NOW(a_start_nonzero, mm_start, (cur_r != '0) && (modulus_r != '0), "zero operand")
  `BBS_ASSERT_NOW(a_result_reduced, mm_stat.done, mm_result < modulus_r, "result not reduced")
  `BBS_ASSERT_NOW(a_ready_unit_idle, in_tready, !mm_stat.busy, "ready while squarer busy")
  `BBS_ASSERT_NEXT(a_start_busy, mm_start, mm_stat.busy, "squarer did not take the start")

endmodule

// ===== rtl/bbs_addmod.sv =====
// ----------------------------------------------------------------------------
// bbs_addmod
// Modular adder: (x + y) mod m for operands already below m.
// ----------------------------------------------------------------------------
module bbs_addmod #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] m,
  output logic [WIDTH-1:0] s
);

  logic [WIDTH:0] sum;
  logic [WIDTH:0] diff;

  assign sum  = {1'b0, x} + {1'b0, y};
  assign diff = sum - {1'b0, m};
  assign s    = (sum >= {1'b0, m}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];

endmodule

// ===== rtl/bbs_mulmod.sv =====
// ----------------------------------------------------------------------------
// bbs_mulmod
// Shift-add modular squarer built around one shared modular adder.
// ----------------------------------------------------------------------------
module bbs_mulmod
  import bbs_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] m,
  output logic [WIDTH-1:0] result,
  output mm_stat_t         stat
);

  localparam int IDX_W = $clog2(WIDTH);
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(WIDTH - 1);

  typedef enum logic [2:0] {
    MM_IDLE = 3'b001,
    MM_RED  = 3'b010,
    MM_MUL  = 3'b100
  } mm_state_t;

  mm_state_t        st_r, st_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] ar_r, ar_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ph_r, ph_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH-1:0] add_y;
  logic [WIDTH-1:0] add_s;

  bbs_addmod #(.WIDTH(WIDTH)) u_addmod (
    .x (acc_r),
    .y (add_y),
    .m (m),
    .s (add_s)
  );

  always_comb begin
    priority if (st_r == MM_RED && ph_r) begin
      add_y = {{(WIDTH-1){1'b0}}, a_r[idx_r]};
    end else if (st_r == MM_MUL && ph_r) begin
      add_y = ar_r;
    end else begin
      add_y = acc_r;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    a_nxt    = a_r;
    ar_nxt   = ar_r;
    acc_nxt  = acc_r;
    idx_nxt  = idx_r;
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    unique case (st_r)
      MM_IDLE: begin
        if (start) begin
          a_nxt   = a;
          acc_nxt = '0;
          idx_nxt = IDX_TOP;
          ph_nxt  = 1'b0;
          if (a >= m) begin
            st_nxt = MM_RED;
          end else begin
            ar_nxt = a;
            st_nxt = MM_MUL;
          end
        end
      end
      MM_RED: begin
        acc_nxt = add_s;
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (idx_r == '0) begin
            ar_nxt  = add_s;
            acc_nxt = '0;
            idx_nxt = IDX_TOP;
            st_nxt  = MM_MUL;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      MM_MUL: begin
        acc_nxt = add_s;
        if (!ph_r && a_r[idx_r]) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (idx_r == '0) begin
            done_nxt = 1'b1;
            st_nxt   = MM_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        st_nxt = MM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MM_IDLE;
      done_r <= 1'b0;
      ph_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      ph_r   <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    ar_r  <= ar_nxt;
    acc_r <= acc_nxt;
    idx_r <= idx_nxt;
  end

  assign result    = acc_r;
  assign stat.busy = (st_r != MM_IDLE);
  assign stat.done = done_r;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the squaring bit generator
// Drives generate and restart requests under several modulus and seed settings.
// Each result is checked against a predictor that tracks the running value.
// Until the back-to-back test, the sender pauses and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb;
  import bbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       error;
  } bits_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;
  logic             in_tvalid;
  logic             in_tready;
  logic [7:0]       in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [7:0]       out_tdata;
  logic             out_tuser;

  logic [31:0]  model_modulus;
  logic [31:0]  model_seed;
  logic [31:0]  model_value;
  logic [31:0]  model_squarings;
  bits_result_t expected_bits[$];
  int           mismatch_count;
  int           idle_cycles;
  int           stall_left;
  bit           idling_on;

  bbs_squaring_bit_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bits_result_t predict_bits(input cmd_t cmd, input logic [3:0] count);
    bits_result_t     r;
    int unsigned      n;
    int unsigned      k;
    longint unsigned  square;
    r = '0;
    if (cmd == CMD_RESTART) begin
      if (model_seed == 0 || model_seed >= model_modulus) begin
        r.error = 1'b1;
      end else begin
        model_value     = model_seed;
        model_squarings = '0;
      end
    end else begin
      n = 32'((count > MAX_BITS) ? MAX_BITS : count);
      for (k = 0; k < n && !r.error; k++) begin
        if (model_modulus == 0 || model_value == 0) begin
          r.error     = 1'b1;
          r.data_byte = '0;
        end else begin
          square          = {32'b0, model_value} * {32'b0, model_value};
          model_value     = 32'(square % {32'b0, model_modulus});
          model_squarings = model_squarings + 1;
          r.data_byte[7 - k] = model_value[0];
        end
      end
    end
    return r;
  endfunction

  task automatic send_request(input cmd_t cmd, input logic [3:0] count);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0000, count};
    do @(posedge clk); while (!in_tready);
    expected_bits.push_back(predict_bits(cmd, count));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_bits.size() != 0);
  endtask

  task automatic configure(input logic [31:0] modulus, input logic [31:0] seed);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_MODULUS;
    cfg_wdata <= modulus;
    @(posedge clk);
    model_modulus = modulus;
    cfg_addr  <= REG_SEED;
    cfg_wdata <= seed;
    @(posedge clk);
    model_seed = seed;
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_request(CMD_GENERATE, 4'd8);
    send_request(CMD_RESTART, 4'd0);
    send_request(CMD_GENERATE, 4'd0);
  endtask

  task automatic test_seed_restart();
    configure(32'd209, 32'd3);
    send_request(CMD_RESTART, 4'd1);
    send_request(CMD_GENERATE, 4'd1);
    send_request(CMD_GENERATE, 4'd8);
    send_request(CMD_GENERATE, 4'd9);
    send_request(CMD_GENERATE, 4'd15);
    send_request(CMD_GENERATE, 4'd0);
  endtask

  task automatic test_seed_limits();
    configure(32'd209, 32'd209);
    send_request(CMD_RESTART, 4'd8);
    configure(32'd209, 32'hFFFF_FFFF);
    send_request(CMD_RESTART, 4'd8);
    configure(32'd209, 32'd208);
    send_request(CMD_RESTART, 4'd8);
    send_request(CMD_GENERATE, 4'd8);
  endtask

  task automatic test_modulus_extremes();
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_request(CMD_RESTART, 4'd0);
    send_request(CMD_GENERATE, 4'd8);
    configure(32'd1, 32'd0);
    send_request(CMD_RESTART, 4'd0);
    send_request(CMD_GENERATE, 4'd2);
  endtask

  task automatic test_zero_operands();
    configure(32'd16, 32'd4);
    send_request(CMD_RESTART, 4'd0);
    send_request(CMD_GENERATE, 4'd3);
    configure(32'd16, 32'd5);
    send_request(CMD_RESTART, 4'd0);
    configure(32'd0, 32'd5);
    send_request(CMD_GENERATE, 4'd1);
    send_request(CMD_RESTART, 4'd1);
  endtask

  task automatic test_unreduced_value();
    configure(32'd209, 32'd200);
    send_request(CMD_RESTART, 4'd0);
    configure(32'd7, 32'd200);
    send_request(CMD_GENERATE, 4'd4);
  endtask

  task automatic test_random_streams();
    logic [31:0] modulus;
    logic [31:0] seed;
    int          pick;
    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 6))
        0:       modulus = $urandom_range(3, 1000);
        1:       modulus = 32'hFFFF_FFFF;
        2:       modulus = (p == 3) ? 32'd0 : 32'd1;
        3:       modulus = $urandom_range(1000, 65535);
        default: modulus = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0:       seed = 32'd0;
        1:       seed = modulus;
        2:       seed = $urandom;
        default: seed = (modulus > 1) ? 1 + ($urandom % (modulus - 1)) : $urandom;
      endcase
      configure(modulus, seed);
      send_request(CMD_RESTART, 4'($urandom_range(0, 15)));
      for (int i = 0; i < 80; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
          send_request(CMD_RESTART, 4'($urandom_range(0, 15)));
        end else if (pick == 2) begin
          send_request(CMD_GENERATE, 4'($urandom_range(0, 15)));
        end else begin
          send_request(CMD_GENERATE, 4'($urandom_range(1, 8)));
        end
        if (p == 4 && i == 40) begin
          drain_results();
        end
      end
    end
  endtask

  task automatic test_back_to_back();
    logic [31:0] modulus;
    modulus = $urandom | 32'h8000_0001;
    configure(modulus, 1 + ($urandom % (modulus - 1)));
    send_request(CMD_RESTART, 4'd8);
    for (int i = 0; i < 100; i++) begin
      send_request(CMD_GENERATE, 4'($urandom_range(1, 8)));
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_addr   <= REG_MODULUS;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= CMD_GENERATE;
    model_modulus   = '0;
    model_seed      = '0;
    model_value     = '0;
    model_squarings = '0;
    mismatch_count  = 0;
    idling_on       = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_seed_restart();
    test_seed_limits();
    test_modulus_extremes();
    test_zero_operands();
    test_unreduced_value();
    test_random_streams();
    drain_results();
    idling_on = 1'b0;
    test_back_to_back();
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    out_tready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_result
    bits_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bits.size() == 0) begin
        $display("%0t ERROR: result with none pending, actual byte %02h error %0b",
                 $time, out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want = expected_bits.pop_front();
        if (out_tdata !== want.data_byte) begin
          $display("%0t ERROR: data_byte expected %02h actual %02h",
                   $time, want.data_byte, out_tdata);
          mismatch_count++;
        end
        if (out_tuser !== want.error) begin
          $display("%0t ERROR: error flag expected %0b actual %0b",
                   $time, want.error, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ERROR: no request moved for %0d cycles", $time, idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
